@@ rtl/core/sm4_pkg.sv @@
// shared constants, types and round functions for the sm4 block encryption pipeline
`default_nettype none

package sm4_pkg;

    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;

    localparam int unsigned HALF_W  = 64;

    // configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    // family key constants
    localparam t_word FK0 = 32'ha3b1bac6;
    localparam t_word FK1 = 32'h56aa3350;
    localparam t_word FK2 = 32'h677d9197;
    localparam t_word FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
        8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
        8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
        8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
        8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
        8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
        8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
        8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
        8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
        8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
        8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
        8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
        8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
        8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
        8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
        8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
        8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
        8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
        8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
        8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
        8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
        8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
        8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
        8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
        8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
        8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
        8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
        8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
        8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
        8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
    };

    function automatic t_word round_const(input int unsigned idx);
        t_word c;
        c = '0;
        for (int unsigned j = 0; j < 4; j++) begin
            c = {c[23:0], 8'((4 * idx + j) * 7)};
        end
        return c;
    endfunction

    function automatic t_word sub_word(input t_word v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic t_word rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_word mix_data(input t_word v);
        t_word t;
        t = sub_word(v);
        return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    endfunction

    function automatic t_word mix_key(input t_word v);
        t_word t;
        t = sub_word(v);
        return t ^ rotl(t, 13) ^ rotl(t, 23);
    endfunction

    // key words {k0,k1,k2,k3} from high to low; newest round key lands in the low word
    function automatic t_block key_round(input t_block kw, input t_word ck);
        t_word a;
        a = kw[95:64] ^ kw[63:32] ^ kw[31:0] ^ ck;
        return {kw[95:0], kw[127:96] ^ mix_key(a)};
    endfunction

    // data words {x0,x1,x2,x3} from high to low
    function automatic t_block data_round(input t_block x, input t_word rk);
        t_word a;
        a = x[95:64] ^ x[63:32] ^ x[31:0] ^ rk;
        return {x[95:0], x[127:96] ^ mix_data(a)};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sm4_stage.sv @@
// one pipeline stage: a data round with the current round key and the next key round
`default_nettype none

module sm4_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire sm4_pkg::t_block i_x,
    input  wire sm4_pkg::t_block i_kw,
    input  wire sm4_pkg::t_word  i_ck,
    output logic                 o_valid,
    output sm4_pkg::t_block      o_x,
    output sm4_pkg::t_block      o_kw
);
    import sm4_pkg::*;

    logic   r_valid;
    t_block r_x;
    t_block r_kw;
    t_block n_x;
    t_block n_kw;

    always_comb begin
        n_x  = data_round(i_x, i_kw[31:0]);
        n_kw = key_round(i_kw, i_ck);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_x  <= n_x;
            r_kw <= n_kw;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_kw    = r_kw;

endmodule

`default_nettype wire

@@ rtl/core/sm4_skid.sv @@
// output skid register that decouples the pipeline from a stalled receiver
`default_nettype none

module sm4_skid (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire sm4_pkg::t_block i_data,
    input  wire logic            i_ready,
    output logic                 o_valid,
    output sm4_pkg::t_block      o_data,
    output logic                 o_en
);
    import sm4_pkg::*;

    logic   r_skid_valid;
    t_block r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            r_skid_valid <= !i_ready;
        end else begin
            r_skid_valid <= i_valid && !i_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && i_valid && !i_ready) begin
            r_skid_data <= i_data;
        end
    end

    assign o_en    = !r_skid_valid;
    assign o_valid = r_skid_valid || i_valid;
    assign o_data  = r_skid_valid ? r_skid_data : i_data;

    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(i_valid && !i_ready))
        else $error("skid filled without a stalled result");

    a_drain_on_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_skid_valid) |-> $past(i_ready))
        else $error("skid drained without a taken result");

    a_hold_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_ready |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid lost a stalled result");

endmodule

`default_nettype wire

@@ rtl/core/sm4_block_encrypt.sv @@
// top level of the sm4 block encryption pipeline
// usage:
//   load the key through the write port (index 0 key bytes 0..7, index 1 key bytes 8..15)
//   while no block is in flight; each block takes the key present when it is accepted
//   s_axis tdata carries one 128-bit plaintext block, m_axis tdata the ciphertext block
//   one block per cycle is accepted; each stage holds one round and its own key words,
//   so the key schedule travels with the block through the pipeline
//   path: a block accepted on s_axis passes through one entry stage with key round 0,
//   then one stage per cipher round, before it reaches m_axis
//   throughput: one block per cycle for as long as the receiver takes results
//   stall: when m_axis_tready is low the pending result moves into a skid register
//   and s_axis_tready drops in the cycle after; the whole pipeline then holds
//   reset: key registers clear to zero and all stage valid bits clear
`default_nettype none

module sm4_block_encrypt #(
    parameter int ROUND_COUNT = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,   // text_high [63:0], text_low [127:64]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [127:0]       m_axis_tdata    // cipher_high [63:0], cipher_low [127:64]
);
    import sm4_pkg::*;

    logic [HALF_W-1:0] r_key_high;
    logic [HALF_W-1:0] r_key_low;

    logic   w_en;
    logic   w_valid [ROUND_COUNT+1];
    t_block w_x     [ROUND_COUNT+1];
    t_block w_kw    [ROUND_COUNT+1];
    t_word  w_ck    [ROUND_COUNT];

    logic   r_valid0;
    t_block r_x0;
    t_block r_kw0;
    t_block n_kw0;
    t_block w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_high <= r_key_high;
            endcase
        end
    end

    always_comb begin
        n_kw0 = key_round({r_key_high[63:32] ^ FK0, r_key_high[31:0] ^ FK1,
                           r_key_low[63:32] ^ FK2, r_key_low[31:0] ^ FK3},
                          round_const(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_en) begin
            r_valid0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && s_axis_tvalid) begin
            r_x0  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            r_kw0 <= n_kw0;
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_x[0]     = r_x0;
    assign w_kw[0]    = r_kw0;

    for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
        assign w_ck[k] = round_const(k + 1);

        sm4_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_x     (w_x[k]),
            .i_kw    (w_kw[k]),
            .i_ck    (w_ck[k]),
            .o_valid (w_valid[k+1]),
            .o_x     (w_x[k+1]),
            .o_kw    (w_kw[k+1])
        );
    end

    // words come out reversed: {x35,x34} low half, {x33,x32} high half
    assign w_out = {w_x[ROUND_COUNT][95:64], w_x[ROUND_COUNT][127:96],
                    w_x[ROUND_COUNT][31:0],  w_x[ROUND_COUNT][63:32]};

    sm4_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[ROUND_COUNT]),
        .i_data  (w_out),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_en    (w_en)
    );

    assign s_axis_tready = w_en;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_valid0)
        else $error("accepted block did not enter the pipeline");

    a_stall_holds_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en && r_valid0 |=> r_valid0 && $stable(r_x0))
        else $error("entry stage changed during a stall");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed before it was taken");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for sm4_block_encrypt: scoreboard, stream drivers, key loading and result checks
`timescale 1ns / 1ps

module tb_top;
    import sm4_pkg::CFG_KEY_HIGH;
    import sm4_pkg::CFG_KEY_LOW;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RAND_PER_KEY = 155;
    localparam logic [63:0] STD_HIGH     = 64'h0123456789abcdef;
    localparam logic [63:0] STD_LOW      = 64'hfedcba9876543210;

    // substitution table, entry 0 in the top byte
    localparam logic [2047:0] SUBST_BITS = {
        128'hD690E9FECCE13DB716B614C228FB2C05, 128'h2B679A762ABE04C3AA44132649860699,
        128'h9C4250F491EF987A33540B43EDCFAC62, 128'hE4B31CA9C908E89580DF94FA758F3FA6,
        128'h4707A7FCF37317BA83593C19E6854FA8, 128'h686B81B27164DA8BF8EB0F4B70569D35,
        128'h1E240E5E6358D1A225227C3B01217887, 128'hD40046579FD327524C3602E7A0C4C89E,
        128'hEABF8AD240C738B5A3F7F2CEF96115A1, 128'hE0AE5DA49B341A55AD933230F58CB1E3,
        128'h1DF6E22E8266CA60C02923AB0D534E6F, 128'hD5DB3745DEFD8E2F03FF6A726D6C5B51,
        128'h8D1BAF92BBDDBC7F11D95C411F105AD8, 128'h0AC13188A5CD7BBD2D74D012B8E5B4B0,
        128'h8969974A0C96777E65B9F109C56EC684, 128'h18F07DEC3ADC4D2079EE5F3ED7CB3948
    };

    class sm4_scoreboard;
        logic [63:0]  key_hi = '0;
        logic [63:0]  key_lo = '0;
        logic [127:0] cipher_q[$];
        int unsigned  failures = 0;

        function void set_key(logic [63:0] hi, logic [63:0] lo);
            key_hi = hi;
            key_lo = lo;
        endfunction

        function logic [31:0] subst_word(logic [31:0] v);
            logic [31:0] r;
            int b;
            for (b = 0; b < 4; b++) begin
                r[8*b +: 8] = SUBST_BITS[2047 - 8 * int'(v[8*b +: 8]) -: 8];
            end
            return r;
        endfunction

        function logic [31:0] rol(logic [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function logic [31:0] ck_word(int i);
            logic [31:0] c;
            int j;
            c = '0;
            for (j = 0; j < 4; j++) begin
                c = {c[23:0], 8'(((4 * i + j) * 7) & 255)};
            end
            return c;
        endfunction

        function logic [127:0] sm4_encrypt(logic [63:0] text_hi, logic [63:0] text_lo);
            logic [31:0] kw[4];
            logic [31:0] rk[32];
            logic [31:0] x[4];
            logic [31:0] t;
            logic [31:0] nx;
            int i;
            kw[0] = key_hi[63:32] ^ 32'ha3b1bac6;
            kw[1] = key_hi[31:0]  ^ 32'h56aa3350;
            kw[2] = key_lo[63:32] ^ 32'h677d9197;
            kw[3] = key_lo[31:0]  ^ 32'hb27022dc;
            for (i = 0; i < 32; i++) begin
                t = subst_word(kw[(i + 1) % 4] ^ kw[(i + 2) % 4] ^ kw[(i + 3) % 4] ^ ck_word(i));
                kw[i % 4] = kw[i % 4] ^ t ^ rol(t, 13) ^ rol(t, 23);
                rk[i] = kw[i % 4];
            end
            x[0] = text_hi[63:32];
            x[1] = text_hi[31:0];
            x[2] = text_lo[63:32];
            x[3] = text_lo[31:0];
            for (i = 0; i < 32; i++) begin
                t = subst_word(x[1] ^ x[2] ^ x[3] ^ rk[i]);
                nx = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
                x[0] = x[1];
                x[1] = x[2];
                x[2] = x[3];
                x[3] = nx;
            end
            // cipher_low {x1,x0} above cipher_high {x3,x2}
            return {x[1], x[0], x[3], x[2]};
        endfunction

        function void note_block(logic [127:0] tdata);
            cipher_q.push_back(sm4_encrypt(tdata[63:0], tdata[127:64]));
        endfunction

        function void check_block(logic [127:0] tdata);
            logic [127:0] exp_blk;
            if (cipher_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected ciphertext block %h", tdata);
                end
                return;
            end
            exp_blk = cipher_q.pop_front();
            if (tdata[63:0] !== exp_blk[63:0] || tdata[127:64] !== exp_blk[127:64]) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch cipher_high exp %h got %h, cipher_low exp %h got %h",
                             exp_blk[63:0], tdata[63:0], exp_blk[127:64], tdata[127:64]);
                end
            end
        endfunction

        function int pending();
            return cipher_q.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = CFG_KEY_HIGH;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // text_high [63:0], text_low [127:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // cipher_high [63:0], cipher_low [127:64]

    sm4_scoreboard sb;
    int unsigned   src_idle_pct = 0;
    int unsigned   sink_idle_pct = 0;
    logic          hold_req = 1'b0;
    logic          hold_done = 1'b0;
    int unsigned   hold_cnt = 0;
    int unsigned   cycle_cnt = 0;

    sm4_block_encrypt u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver side, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_block(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_block(m_axis_tdata);
            end
        end
    end

    function automatic logic [63:0] pick_half();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic [63:0] text_hi, input logic [63:0] text_lo);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {text_lo, text_hi};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_blocks();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx <= CFG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_key(hi, lo);
    endtask

    initial begin
        int p;
        int k;
        int n;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 11;
        sink_idle_pct <= 47;

        // key left at its reset value
        send_block('0, '0);
        send_block('1, '1);
        send_block(STD_HIGH, STD_LOW);
        send_block({16{4'h5}}, {16{4'ha}});
        send_block({16{4'ha}}, {16{4'h5}});
        send_block(64'h8000000000000000, 64'h0000000000000001);
        send_block(64'h0000000000000001, 64'h8000000000000000);
        drain_blocks();

        // standard key and plaintext
        load_key(STD_HIGH, STD_LOW);
        send_block(STD_HIGH, STD_LOW);
        send_block('0, '0);
        send_block('1, '1);
        send_block(STD_LOW, STD_HIGH);
        drain_blocks();

        load_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block({16{4'h5}}, {16{4'ha}});
        drain_blocks();

        load_key('0, '1);
        send_block('0, '1);
        send_block('1, '0);
        drain_blocks();

        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    src_idle_pct = 11;
                    sink_idle_pct <= 47;
                end
                1: begin
                    src_idle_pct = 47;
                    sink_idle_pct <= 11;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct <= 0;
                end
            endcase
            for (k = 0; k < 3; k++) begin
                if (p == 0 && k == 0) begin
                    load_key('1, '0);
                end else begin
                    load_key(pick_half(), pick_half());
                end
                if (p == 2 && k == 0) begin
                    hold_req <= 1'b1;
                end
                for (n = 0; n < RAND_PER_KEY; n++) begin
                    send_block(pick_half(), pick_half());
                end
                drain_blocks();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
